FILE: hw/rtl/sli_pkg.sv
// shared types and constants for the sorted insertion list
`timescale 1ns / 1ps
package sli_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned VAL_W = 8;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned CNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST     = 2'd2;
  // spare encoding, decoded as a list request as well
  localparam logic [CMD_W-1:0] CMD_LIST_ALT = 2'd3;
  // any command with the high bit set lists the entries
  localparam int unsigned CMD_LIST_BIT = 1;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // mode of the shared compare unit
  typedef enum logic {
    CMP_GT = 1'b0,
    CMP_EQ = 1'b1
  } cmp_mode_e;

endpackage

FILE: hw/rtl/sli_if.sv
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps
interface sli_in_if;
  import sli_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface sli_out_if;
  import sli_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [VAL_W-1:0]  entry;
  logic [CNT_W-1:0]         count;
  logic                     last;

  modport source (output valid, output status, output entry, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input entry, input count, input last,
                  output ready);
endinterface

FILE: hw/rtl/sorted_list_insert_delete.sv
// sorted insertion list: ram of entries walked by a sequencer around one compare unit
//
//   channel | dir | payload                       | transfer when
//   in_i    | in  | command, value                | valid && ready
//   out_o   | out | status, entry, count, last    | valid && ready
//
// ready on in_i is high only while the sequencer is idle; one command is in flight.
// insert walks down from the top, one ram read then one compare/write per entry looked at.
// delete scans up, one ram read then one compare per entry looked at, then one read and
// one write per entry shifted down, then the result. list gives one result per entry, each
// after its own ram read, and waits while the output stalls. a full insert, or any command
// on an empty list, goes straight to the result step. in_i is ready again the cycle after
// the result is set. reset empties the list at once (fill count cleared); stored values
// are not cleared. a stalled result holds the sequencer at its result step.
`timescale 1ns / 1ps
module sorted_list_insert_delete #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sli_in_if.sink    in_i,
  sli_out_if.source out_o
);
  import sli_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_IRD,
    S_IEV,
    S_IWV,
    S_DRD,
    S_DEV,
    S_SRD,
    S_SEV,
    S_LRD,
    S_LEV,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           fill_q, fill_d;
  status_e                 st_q, st_d;

  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic signed [VAL_W-1:0] out_entry_q, out_entry_d;
  logic [CNT_W-1:0]        out_count_q, out_count_d;
  logic                    out_last_q, out_last_d;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [VAL_W-1:0]        wdata;
  logic [AW-1:0]           raddr;
  logic [VAL_W-1:0]        rdata;
  cmp_mode_e               cmp_mode;
  logic                    hit;
  logic                    slot_free;
  logic                    in_fire;
  logic [CW-1:0]           idx_m1;
  logic [CW-1:0]           idx_p1;
  logic [CW-1:0]           idx_p2;

  sli_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sli_cmp u_cmp (
    .mode_i (cmp_mode),
    .key_i  (val_q),
    .elem_i ($signed(rdata)),
    .hit_o  (hit)
  );

  assign in_i.ready   = (state_q == S_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign slot_free    = !out_valid_q || out_o.ready;
  assign idx_m1       = idx_q - CW'(1);
  assign idx_p1       = idx_q + CW'(1);
  assign idx_p2       = idx_q + CW'(2);
  assign cmp_mode     = (state_q == S_DEV) ? CMP_EQ : CMP_GT;

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.entry  = out_entry_q;
  assign out_o.count  = out_count_q;
  assign out_o.last   = out_last_q;

  always_comb begin
    state_d      = state_q;
    val_d        = val_q;
    idx_d        = idx_q;
    fill_d       = fill_q;
    st_d         = st_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    we           = 1'b0;
    waddr        = idx_q[AW-1:0];
    wdata        = val_q;
    raddr        = idx_q[AW-1:0];

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d = in_i.value;
          idx_d = '0;
          if (in_i.command[CMD_LIST_BIT]) begin
            if (fill_q == '0) begin
              st_d    = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              state_d = S_LRD;
            end
          end else if (in_i.command == CMD_INSERT) begin
            if (fill_q >= CW'(DEPTH)) begin
              st_d    = ST_FULL;
              state_d = S_DONE;
            end else if (fill_q == '0) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = in_i.value;
              fill_d  = CW'(1);
              st_d    = ST_INSERTED;
              state_d = S_DONE;
            end else begin
              idx_d   = fill_q;
              state_d = S_IRD;
            end
          end else begin
            if (fill_q == '0) begin
              st_d    = ST_NOT_FOUND;
              state_d = S_DONE;
            end else begin
              state_d = S_DRD;
            end
          end
        end
      end
      S_IRD: begin
        raddr   = idx_m1[AW-1:0];
        state_d = S_IEV;
      end
      S_IEV: begin
        we = 1'b1;
        if (hit) begin
          wdata   = val_q;
          fill_d  = fill_q + CW'(1);
          st_d    = ST_INSERTED;
          state_d = S_DONE;
        end else begin
          // move the larger-or-equal entry up one place
          wdata = rdata;
          idx_d = idx_m1;
          state_d = (idx_m1 == '0) ? S_IWV : S_IRD;
        end
      end
      S_IWV: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        fill_d  = fill_q + CW'(1);
        st_d    = ST_INSERTED;
        state_d = S_DONE;
      end
      S_DRD: begin
        state_d = S_DEV;
      end
      S_DEV: begin
        if (hit) begin
          if (idx_p1 == fill_q) begin
            fill_d  = fill_q - CW'(1);
            st_d    = ST_REMOVED;
            state_d = S_DONE;
          end else begin
            state_d = S_SRD;
          end
        end else if (idx_p1 == fill_q) begin
          st_d    = ST_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          idx_d   = idx_p1;
          state_d = S_DRD;
        end
      end
      S_SRD: begin
        raddr   = idx_p1[AW-1:0];
        state_d = S_SEV;
      end
      S_SEV: begin
        // close the gap by pulling the next entry down
        we    = 1'b1;
        wdata = rdata;
        idx_d = idx_p1;
        if (idx_p2 == fill_q) begin
          fill_d  = fill_q - CW'(1);
          st_d    = ST_REMOVED;
          state_d = S_DONE;
        end else begin
          state_d = S_SRD;
        end
      end
      S_LRD: begin
        state_d = S_LEV;
      end
      S_LEV: begin
        // raddr stays on idx so the read data holds while the output stalls
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_ENTRY;
          out_entry_d  = $signed(rdata);
          out_count_d  = CNT_W'(fill_q);
          out_last_d   = (idx_p1 == fill_q);
          if (idx_p1 == fill_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_p1;
            state_d = S_LRD;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_entry_d  = '0;
          out_count_d  = CNT_W'(fill_q);
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    idx_q        <= idx_d;
    st_q         <= st_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

endmodule

FILE: hw/rtl/sli_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sli_cmp.sv
// shared compare unit: key greater than element, or key equal to element
`timescale 1ns / 1ps
module sli_cmp (
  input  sli_pkg::cmp_mode_e       mode_i,
  input  logic signed [sli_pkg::VAL_W-1:0] key_i,
  input  logic signed [sli_pkg::VAL_W-1:0] elem_i,
  output logic                     hit_o
);
  import sli_pkg::*;

  always_comb begin
    case (mode_i)
      CMP_GT:  hit_o = key_i > elem_i;
      CMP_EQ:  hit_o = key_i == elem_i;
      default: hit_o = 1'b0;
    endcase
  end

endmodule

FILE: tb/sorted_list_insert_delete_test.sv
// testbench for the sorted insertion list: random and directed commands against a list model
`timescale 1ns / 1ps
module sorted_list_insert_delete_test;
  import sli_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;

  typedef struct {
    status_e                 status;
    logic signed [VAL_W-1:0] entry;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } list_result_t;

  class list_scoreboard;
    logic signed [VAL_W-1:0] cells[$];
    list_result_t            awaited[$];
    int                      errors = 0;

    function void add_result(status_e st, logic signed [VAL_W-1:0] e, logic fin);
      list_result_t r;
      r.status = st;
      r.entry  = e;
      r.count  = CNT_W'(cells.size());
      r.last   = fin;
      awaited.push_back(r);
    endfunction

    // applies one accepted command to the list copy and queues what it should produce
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val);
      int pos;
      pos = 0;
      if (cmd[CMD_LIST_BIT]) begin
        if (cells.size() == 0) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (cells[i]) add_result(ST_ENTRY, cells[i], i == cells.size() - 1);
        end
      end else if (cmd == CMD_INSERT) begin
        if (cells.size() >= LIST_DEPTH) begin
          add_result(ST_FULL, '0, 1'b1);
        end else begin
          // equal values go in front of the ones already stored
          while (pos < cells.size() && val > cells[pos]) pos++;
          cells.insert(pos, val);
          add_result(ST_INSERTED, '0, 1'b1);
        end
      end else begin
        while (pos < cells.size() && cells[pos] != val) pos++;
        if (pos >= cells.size()) begin
          add_result(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          cells.delete(pos);
          add_result(ST_REMOVED, '0, 1'b1);
        end
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: status %0d entry %0d count %0d last %0d",
               got.status, got.entry, got.count, got.last);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.entry !== want.entry) begin
        $error("entry: expected %0d, got %0d", want.entry, got.entry);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   no_idle = 1'b0;

  list_scoreboard sb = new();

  sli_in_if  cmd_if ();
  sli_out_if res_if ();

  sorted_list_insert_delete #(
    .DEPTH (LIST_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if.sink),
    .out_o  (res_if.source)
  );

  always #6 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid   = 1'b0;
      cmd_if.command = CMD_W'($urandom);
      cmd_if.value   = VAL_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid   = 1'b1;
    cmd_if.command = cmd;
    cmd_if.value   = val;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sb.note_command(cmd, val);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    cmd_if.valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
  endtask

  // result side
  initial begin
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        stall--;
      end else begin
        res_if.ready = 1'b1;
        if ($urandom_range(0, 7) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    list_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.status = status_e'(res_if.status);
      got.entry  = res_if.entry;
      got.count  = res_if.count;
      got.last   = res_if.last;
      sb.check_result(got);
    end
  end

  initial begin
    logic signed [VAL_W-1:0] val;
    int                      r;
    bit                      grow;
    bit                      narrow;

    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_INSERT;
    cmd_if.value   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty list: listing, deleting, and the spare list encoding
    send_cmd(CMD_LIST, 8'sd0);
    send_cmd(CMD_DELETE, 8'sd0);
    send_cmd(CMD_LIST_ALT, -8'sd1);
    // extremes and duplicates
    send_cmd(CMD_INSERT, 8'sd127);
    send_cmd(CMD_INSERT, -8'sd128);
    send_cmd(CMD_INSERT, 8'sd0);
    send_cmd(CMD_INSERT, -8'sd1);
    send_cmd(CMD_INSERT, 8'sd1);
    send_cmd(CMD_INSERT, 8'sd0);
    send_cmd(CMD_INSERT, -8'sd128);
    send_cmd(CMD_INSERT, 8'sd127);
    send_cmd(CMD_LIST, 8'sd0);
    send_cmd(CMD_DELETE, 8'sd0);
    send_cmd(CMD_DELETE, 8'sd5);
    send_cmd(CMD_DELETE, -8'sd128);
    send_cmd(CMD_DELETE, 8'sd127);
    send_cmd(CMD_LIST_ALT, 8'sd0);
    // fill up, then push past full
    while (sb.cells.size() < LIST_DEPTH) send_cmd(CMD_INSERT, VAL_W'($urandom));
    send_cmd(CMD_INSERT, 8'sd0);
    send_cmd(CMD_INSERT, -8'sd128);
    send_cmd(CMD_LIST, 8'sd0);

    // alternate growing and shrinking so the list keeps crossing full and empty
    for (int ph = 0; ph < 6; ph++) begin
      grow    = (ph % 2) == 0;
      narrow  = (ph == 2) || (ph == 3);
      no_idle = (ph == 4);
      repeat (73) begin
        r = $urandom_range(0, 99);
        if (narrow) val = VAL_W'($urandom_range(0, 6)) - VAL_W'(3);
        else val = VAL_W'($urandom);
        if (r < 15) begin
          send_cmd(($urandom_range(0, 1) != 0) ? CMD_LIST : CMD_LIST_ALT,
                   VAL_W'($urandom));
        end else if (r < (grow ? 70 : 35)) begin
          send_cmd(CMD_INSERT, val);
        end else begin
          if ($urandom_range(0, 3) != 0 && sb.cells.size() > 0)
            val = sb.cells[$urandom_range(0, sb.cells.size() - 1)];
          send_cmd(CMD_DELETE, val);
        end
      end
      if (ph == 2) wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (60) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("sorted_list_insert_delete_test: clean");
    end else begin
      $display("sorted_list_insert_delete_test: errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("sorted_list_insert_delete_test: errors");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/sli_pkg.sv
hw/rtl/sli_if.sv
hw/rtl/sli_ram.sv
hw/rtl/sli_cmp.sv
hw/rtl/sorted_list_insert_delete.sv
tb/sorted_list_insert_delete_test.sv
